// ===== rtl/vcs_pkg.sv =====
// ----------------------------------------------------------------------------
// vcs_pkg
// shared constants, tables and controller/datapath interface types for the
// vector command to segment converter
// ----------------------------------------------------------------------------
`default_nettype none

package vcs_pkg;

  // ring geometry
  localparam int SEGMENTS    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int NCHORD      = (SEGMENTS > MAX_RESULTS) ? MAX_RESULTS : SEGMENTS;
  localparam int IDX_W       = $clog2(NCHORD + 1);
  localparam int ANG_W       = 6;

  // field widths
  localparam int COORD_W = 16;
  localparam int COLOR_W = 8;
  localparam int COUNT_W = 17;
  localparam int LIMIT_W = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  // command codes
  localparam logic [2:0] CMD_COLOR = 3'd0;
  localparam logic [2:0] CMD_MOVE  = 3'd1;
  localparam logic [2:0] CMD_LINE  = 3'd2;
  localparam logic [2:0] CMD_TRI   = 3'd3;
  localparam logic [2:0] CMD_DOT   = 3'd4;

  // output kind codes
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  // angle step (of 64 per turn) for each ring point, worked out at elaboration
  function automatic logic [(NCHORD+1)*ANG_W-1:0] build_angles();
    logic [(NCHORD+1)*ANG_W-1:0] v;
    v = '0;
    for (int i = 0; i <= NCHORD; i++) begin
      v[i*ANG_W +: ANG_W] = ANG_W'(((i * 64) + SEGMENTS / 2) / SEGMENTS);
    end
    return v;
  endfunction

  localparam logic [(NCHORD+1)*ANG_W-1:0] ANGLE_LUT = build_angles();

  // first quadrant cosine, Q1.14
  function automatic logic [14:0] qcos(input logic [4:0] m);
    logic [14:0] c;
    case (m)
      5'd0:    c = 15'd16384;
      5'd1:    c = 15'd16305;
      5'd2:    c = 15'd16069;
      5'd3:    c = 15'd15679;
      5'd4:    c = 15'd15137;
      5'd5:    c = 15'd14449;
      5'd6:    c = 15'd13623;
      5'd7:    c = 15'd12665;
      5'd8:    c = 15'd11585;
      5'd9:    c = 15'd10394;
      5'd10:   c = 15'd9102;
      5'd11:   c = 15'd7723;
      5'd12:   c = 15'd6270;
      5'd13:   c = 15'd4756;
      5'd14:   c = 15'd3196;
      5'd15:   c = 15'd1606;
      default: c = 15'd0;
    endcase
    return c;
  endfunction

  // full turn cosine from the quadrant table
  function automatic logic signed [15:0] cos64(input logic [ANG_W-1:0] k);
    logic [4:0]         m;
    logic [4:0]         mr;
    logic signed [15:0] pos;
    logic signed [15:0] mir;
    logic signed [15:0] c;
    m   = {1'b0, k[3:0]};
    mr  = 5'd16 - m;
    pos = $signed({1'b0, qcos(m)});
    mir = $signed({1'b0, qcos(mr)});
    case (k[5:4])
      2'd0:    c = pos;
      2'd1:    c = -mir;
      2'd2:    c = -pos;
      default: c = mir;
    endcase
    return c;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic             accept;  // input beat taken this cycle
    logic             mul;     // multiply radius by table entries
    logic             add;     // round, add pen, saturate into point
    logic             emit;    // load a chord into the output register
    logic [IDX_W-1:0] idx;     // ring point index
  } vcs_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
    logic dot_go;    // offered command is a dot that will be carried out
  } vcs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/vcs_datapath.sv =====
// ----------------------------------------------------------------------------
// vcs_datapath
// list state, ring point arithmetic and output register
// ----------------------------------------------------------------------------
`default_nettype none

module vcs_datapath import vcs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]  cfg_wr_data,
  input  wire logic [3:0]          in_tuser,
  input  wire logic [63:0]         in_tdata,
  input  wire vcs_ctl_t            ctl,
  output vcs_stat_t                stat,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic                     out_tuser,
  output logic [119:0]             out_tdata,
  output logic                     out_tlast
);

  function automatic logic [COLOR_W-1:0] color_of(input logic signed [15:0] f);
    logic [8:0]  fc;
    logic [16:0] p;
    if (f < 0) begin
      fc = 9'd0;
    end else if (f > 16'sd256) begin
      fc = 9'd256;
    end else begin
      fc = f[8:0];
    end
    p = 17'(fc) * 17'd255;
    return p[15:8];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [LIMIT_W-1:0]        limit_r;
  logic [COUNT_W-1:0]        count_r;
  logic signed [COORD_W-1:0] pen_x_r, pen_y_r;
  logic [COLOR_W-1:0]        red_r, green_r, blue_r;
  logic signed [COORD_W-1:0] radius_r;
  logic signed [31:0]        prod_x_r, prod_y_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;

  logic                      out_valid_r;
  logic                      out_kind_r, out_last_r;
  logic signed [COORD_W-1:0] out_ax_r, out_ay_r, out_bx_r, out_by_r, out_cx_r, out_cy_r;
  logic [COLOR_W-1:0]        out_red_r, out_green_r, out_blue_r;

  // input beat fields
  logic [2:0]                cmd;
  logic                      first;
  logic signed [COORD_W-1:0] a0, a1, a2, a3;

  assign cmd   = in_tuser[2:0];
  assign first = in_tuser[3];
  assign a0    = $signed(in_tdata[15:0]);
  assign a1    = $signed(in_tdata[31:16]);
  assign a2    = $signed(in_tdata[47:32]);
  assign a3    = $signed(in_tdata[63:48]);

  // state as seen after an optional list restart
  logic [COUNT_W-1:0]        eff_count, count_nxt;
  logic signed [COORD_W-1:0] eff_pen_x, eff_pen_y;
  logic [COLOR_W-1:0]        eff_red, eff_green, eff_blue;
  logic                      active;

  assign eff_count = first ? '0 : count_r;
  assign eff_pen_x = first ? '0 : pen_x_r;
  assign eff_pen_y = first ? '0 : pen_y_r;
  assign eff_red   = first ? '0 : red_r;
  assign eff_green = first ? '0 : green_r;
  assign eff_blue  = first ? '0 : blue_r;
  assign active    = {1'b0, limit_r} > eff_count;
  assign count_nxt = (eff_count == COUNT_MAX) ? eff_count : eff_count + 1'b1;

  logic line_ld, tri_ld, out_ld;
  assign line_ld = ctl.accept && active && (cmd == CMD_LINE);
  assign tri_ld  = ctl.accept && active && (cmd == CMD_TRI);
  assign out_ld  = line_ld || tri_ld || ctl.emit;

  assign stat.out_free = !out_valid_r || out_tready;
  assign stat.dot_go   = active && (cmd == CMD_DOT);

  // ring point arithmetic
  logic [ANG_W-1:0]   ang_c, ang_s;
  logic signed [31:0] sum_x, sum_y;
  logic signed [17:0] pt_x, pt_y;

  assign ang_c = ANGLE_LUT[ctl.idx*ANG_W +: ANG_W];
  assign ang_s = ang_c + ANG_W'(48);
  assign sum_x = prod_x_r + 32'sd8192;
  assign sum_y = prod_y_r + 32'sd8192;
  assign pt_x  = $signed({{2{pen_x_r[15]}}, pen_x_r}) + $signed(sum_x[31:14]);
  assign pt_y  = $signed({{2{pen_y_r[15]}}, pen_y_r}) + $signed(sum_y[31:14]);

  // list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      count_r <= '0;
      pen_x_r <= '0;
      pen_y_r <= '0;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (ctl.accept) begin
        count_r <= count_nxt;
        pen_x_r <= eff_pen_x;
        pen_y_r <= eff_pen_y;
        red_r   <= eff_red;
        green_r <= eff_green;
        blue_r  <= eff_blue;
        if (active) begin
          case (cmd) inside
            CMD_COLOR: begin
              red_r   <= color_of(a0);
              green_r <= color_of(a1);
              blue_r  <= color_of(a2);
            end
            CMD_MOVE, CMD_LINE: begin
              pen_x_r <= a0;
              pen_y_r <= a1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // ring arithmetic registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      radius_r <= a0;
    end
    if (ctl.mul) begin
      prod_x_r <= radius_r * cos64(ang_c);
      prod_y_r <= radius_r * cos64(ang_s);
    end
    if (ctl.add) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
      cur_x_r  <= sat16(pt_x);
      cur_y_r  <= sat16(pt_y);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_ld || tri_ld) begin
      out_kind_r  <= tri_ld ? KIND_TRI : KIND_LINE;
      out_ax_r    <= eff_pen_x;
      out_ay_r    <= eff_pen_y;
      out_bx_r    <= a0;
      out_by_r    <= a1;
      out_cx_r    <= tri_ld ? a2 : '0;
      out_cy_r    <= tri_ld ? a3 : '0;
      out_red_r   <= eff_red;
      out_green_r <= eff_green;
      out_blue_r  <= eff_blue;
      out_last_r  <= 1'b1;
    end else if (ctl.emit) begin
      out_kind_r  <= KIND_LINE;
      out_ax_r    <= prev_x_r;
      out_ay_r    <= prev_y_r;
      out_bx_r    <= cur_x_r;
      out_by_r    <= cur_y_r;
      out_cx_r    <= '0;
      out_cy_r    <= '0;
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
      out_last_r  <= (ctl.idx == IDX_W'(NCHORD));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_blue_r, out_green_r, out_red_r, out_cy_r, out_cx_r,
                       out_by_r, out_bx_r, out_ay_r, out_ax_r};

  // a waiting beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // a restarted list counts the restarting command only
  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.accept && first) |=> (count_r == COUNT_W'(1)))
    else $error("command count wrong after list restart");

  // the pen holds while a ring is worked out
  a_pen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mul || ctl.add || ctl.emit) |=> ($stable(pen_x_r) && $stable(pen_y_r)))
    else $error("pen moved during dot");

endmodule

`default_nettype wire

// ===== rtl/vcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// vcs_ctrl
// sequencer for input acceptance and the chord loop of a dot
// ----------------------------------------------------------------------------
`default_nettype none

module vcs_ctrl import vcs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire vcs_stat_t  stat,
  output vcs_ctl_t        ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;
  logic             ring_done;

  assign in_tready = (state_r == ST_IDLE) && stat.out_free;
  assign accept    = in_tvalid && in_tready;
  assign ring_done = (idx_r == IDX_W'(NCHORD));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ctl       = '0;
    ctl.idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        ctl.accept = accept;
        if (accept && stat.dot_go) begin
          state_nxt = ST_MUL;
          idx_nxt   = '0;
        end
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        ctl.add = 1'b1;
        if (idx_r == '0) begin
          // first point only primes the chord start
          idx_nxt   = IDX_W'(1);
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          if (ring_done) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(NCHORD))
    else $error("ring index out of range");

  a_mul_then_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_ADD))
    else $error("multiply not followed by point update");

  a_emit_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r != '0))
    else $error("chord emitted without a start point");

endmodule

`default_nettype wire

// ===== rtl/vector_command_to_segments.sv =====
// ----------------------------------------------------------------------------
// vector_command_to_segments
// display list processor: drawing commands in, line segments and triangles out
// ----------------------------------------------------------------------------
// Each input beat is one drawing command (color, move, line to, triangle, dot).
// The block keeps a pen, a current color and a per-list command count; a beat
// with the first flag restarts the list before it is handled, and commands at
// or past command_limit are counted but dropped. Color, move and unused codes
// give no output beat; line to and triangle give one beat; a dot gives a ring
// of chords (32 by default, tlast on the final one) around the pen. A command
// other than a dot is accepted while the block is idle and the output
// register can take a beat. A dot is carried out before the next command is
// accepted: one shared pair of 16x16 multipliers works out each ring point in
// turn, and each chord is then loaded into the output register, which output
// back pressure can hold up. There is no clearing pass after reset.
// command_limit may only be written while no command is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_command_to_segments import vcs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [LIMIT_W-1:0] cfg_wr_data,   // command_limit
  // command stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [63:0]        in_tdata,      // arg0, arg1, arg2, arg3
  input  wire logic [3:0]         in_tuser,      // cmd[2:0], first
  // result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [119:0]            out_tdata,     // ax, ay, bx, by, cx, cy, red, green, blue
  output logic                    out_tuser,     // kind
  output logic                    out_tlast      // last chord of a dot, or single result
);

  vcs_ctl_t  ctl;
  vcs_stat_t stat;

  // sequencer: acceptance and the chord loop
  vcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // list state, ring arithmetic and the output register
  vcs_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .ctl         (ctl),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/vector_command_to_segments_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_command_to_segments_checker
// watches the command, result and configuration ports, keeps its own pen,
// color, list count and limit, and compares every result beat with the
// oldest predicted segment
// ----------------------------------------------------------------------------

module vector_command_to_segments_checker import vcs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [63:0]        in_tdata,    // arg0, arg1, arg2, arg3
  input  logic [3:0]         in_tuser,    // cmd[2:0], first
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [119:0]       out_tdata,   // ax, ay, bx, by, cx, cy, red, green, blue
  input  logic               out_tuser,   // kind
  input  logic               out_tlast,
  output int                 fail_count,
  output int                 pending_beats
);

  localparam int CHORDS     = (SEGMENTS > MAX_RESULTS) ? MAX_RESULTS : SEGMENTS;

  typedef struct packed {
    logic        kind;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] bx;
    logic [15:0] by;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } segment_t;

  segment_t           expected_segs[$];
  logic [LIMIT_W-1:0] cmd_limit;
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic [7:0]         red_now;
  logic [7:0]         green_now;
  logic [7:0]         blue_now;
  logic [COUNT_W-1:0] list_count;
  int                 segs_seen;

  initial begin
    fail_count    = 0;
    pending_beats = 0;
    segs_seen     = 0;
  end

  // first quadrant of the Q1.14 cosine
  function automatic int quarter_cos(input int m);
    case (m)
      0:  return 16384;
      1:  return 16305;
      2:  return 16069;
      3:  return 15679;
      4:  return 15137;
      5:  return 14449;
      6:  return 13623;
      7:  return 12665;
      8:  return 11585;
      9:  return 10394;
      10: return 9102;
      11: return 7723;
      12: return 6270;
      13: return 4756;
      14: return 3196;
      15: return 1606;
      default: return 0;
    endcase
  endfunction

  // cosine at step k of a 64-step turn
  function automatic int turn_cos(input int k);
    int quad;
    int m;
    quad = (k / 16) % 4;
    m    = k % 16;
    case (quad)
      0:       return quarter_cos(m);
      1:       return -quarter_cos(16 - m);
      2:       return -quarter_cos(m);
      default: return quarter_cos(16 - m);
    endcase
  endfunction

  // r * c / 2^14, round to nearest with ties upward
  function automatic int scaled(input int r, input int c);
    longint p;
    p = longint'(r) * longint'(c) + 64'sd8192;
    return int'(p >>> 14);
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767)  return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [7:0] color_level(input int f);
    int g;
    g = (f < 0) ? 0 : ((f > 256) ? 256 : f);
    return 8'((g * 255) >> 8);
  endfunction

  task automatic report(input string msg);
    $display("checker: %s", msg);
    fail_count++;
  endtask

  task automatic push_segment(input logic kind, input logic [15:0] ax, ay, bx, by,
                              cx, cy, input logic last);
    segment_t s;
    s = '{kind, ax, ay, bx, by, cx, cy, red_now, green_now, blue_now, last};
    expected_segs.push_back(s);
  endtask

  task automatic ring_point(input int i, input int r, output logic [15:0] x, y);
    int k;
    k = ((i * 64 + SEGMENTS / 2) / SEGMENTS) % 64;
    x = clamp16(int'(pen_x) + scaled(r, turn_cos(k)));
    y = clamp16(int'(pen_y) + scaled(r, turn_cos((k + 48) % 64)));
  endtask

  task automatic clear_list();
    pen_x      = '0;
    pen_y      = '0;
    red_now    = '0;
    green_now  = '0;
    blue_now   = '0;
    list_count = '0;
  endtask

  // one accepted command beat
  task automatic run_command(input logic [2:0] cmd, input logic first,
                             input logic signed [15:0] a0, a1, a2, a3);
    logic        active;
    logic [15:0] x0, y0, x1, y1;
    if (first) clear_list();
    active = int'(list_count) < int'(cmd_limit);
    if (list_count != COUNT_MAX) list_count++;
    if (active) begin
      case (cmd)
        CMD_COLOR: begin
          red_now   = color_level(int'(a0));
          green_now = color_level(int'(a1));
          blue_now  = color_level(int'(a2));
        end
        CMD_MOVE: begin
          pen_x = a0;
          pen_y = a1;
        end
        CMD_LINE: begin
          push_segment(KIND_LINE, pen_x, pen_y, a0, a1, '0, '0, 1'b1);
          pen_x = a0;
          pen_y = a1;
        end
        CMD_TRI: begin
          push_segment(KIND_TRI, pen_x, pen_y, a0, a1, a2, a3, 1'b1);
        end
        CMD_DOT: begin
          for (int i = 0; i < CHORDS; i++) begin
            ring_point(i, int'(a0), x0, y0);
            ring_point(i + 1, int'(a0), x1, y1);
            push_segment(KIND_LINE, x0, y0, x1, y1, '0, '0, i == CHORDS - 1);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] got, want);
    if (got !== want)
      report($sformatf("segment %0d: %s is %0h, expected %0h", segs_seen, name, got, want));
  endtask

  task automatic check_segment();
    segment_t want;
    if (expected_segs.size() == 0) begin
      report($sformatf("segment %0d arrived with none expected", segs_seen));
    end else begin
      want = expected_segs.pop_front();
      compare_field("kind",  16'(out_tuser),         16'(want.kind));
      compare_field("ax",    out_tdata[15:0],        want.ax);
      compare_field("ay",    out_tdata[31:16],       want.ay);
      compare_field("bx",    out_tdata[47:32],       want.bx);
      compare_field("by",    out_tdata[63:48],       want.by);
      compare_field("cx",    out_tdata[79:64],       want.cx);
      compare_field("cy",    out_tdata[95:80],       want.cy);
      compare_field("red",   16'(out_tdata[103:96]),  16'(want.red));
      compare_field("green", 16'(out_tdata[111:104]), 16'(want.green));
      compare_field("blue",  16'(out_tdata[119:112]), 16'(want.blue));
      compare_field("last",  16'(out_tlast),          16'(want.last));
    end
    segs_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_limit = LIMIT_RESET;
      clear_list();
      expected_segs.delete();
    end else begin
      // results leave before the command taken at this edge can add any
      if (out_tvalid && out_tready) check_segment();
      if (cfg_wr_en) cmd_limit = cfg_wr_data;
      if (in_tvalid && in_tready)
        run_command(in_tuser[2:0], in_tuser[3], in_tdata[15:0], in_tdata[31:16],
                    in_tdata[47:32], in_tdata[63:48]);
    end
    pending_beats = expected_segs.size();
  end

endmodule

// ===== tb/vector_command_to_segments_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_command_to_segments_tb
// drives drawing commands into the display list processor and gives the verdict
// ----------------------------------------------------------------------------
// A short directed list hits color clamping, coordinate extremes, triangles,
// dots with saturating, negative and zero radius, and the unused opcodes.
// Random lists of commands follow under several command limits (reset value,
// small limits, zero, one, random, full), with the sender in bursts and the
// result side stalling on its own pattern. The checker alongside the block
// predicts every segment and counts mismatches.
// ----------------------------------------------------------------------------

module vector_command_to_segments_tb import vcs_pkg::*;;

  // opcodes the block counts but never draws
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_SCARCE} ready_mode_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [63:0]        in_tdata    = '0;   // arg0, arg1, arg2, arg3
  logic [3:0]         in_tuser    = '0;   // cmd[2:0], first
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [119:0]       out_tdata;          // ax, ay, bx, by, cx, cy, red, green, blue
  logic               out_tuser;          // kind
  logic               out_tlast;

  int          fail_count;
  int          pending_beats;
  int          cycle_count = 0;
  int          burst_left  = 4;
  ready_mode_t ready_mode  = READY_ALWAYS;

  initial forever #5 clk = ~clk;

  vector_command_to_segments dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  vector_command_to_segments_checker seg_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side back pressure: a randomly chosen stall pattern, chosen anew at regular intervals
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS:   out_tready <= 1'b1;
      READY_MOSTLY:   out_tready <= ($urandom_range(0, 3) != 0);
      READY_PERIODIC: out_tready <= (cycle_count % 5 != 0);
      default:        out_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // one command beat; valid stays up across a burst and drops for a random gap
  task automatic send_cmd(input logic [2:0] cmd, input logic first,
                          input logic [15:0] a0, a1, a2, a3);
    in_tuser  <= {first, cmd};
    in_tdata  <= {a3, a2, a1, a0};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
  endtask

  // stop sending until every predicted segment is out, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_beats != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // extremes, small values near the origin, or anything
  function automatic logic [15:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  // mostly the legal 0..256 range, sometimes out of it on either side
  function automatic logic [15:0] random_color();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return 16'd256;
      default: return 16'($urandom_range(0, 256));
    endcase
  endfunction

  task automatic send_random(input logic first);
    int          pick;
    logic [2:0]  cmd;
    logic [15:0] a0, a1, a2, a3;
    pick = $urandom_range(0, 99);
    a0   = random_coord();
    a1   = random_coord();
    a2   = random_coord();
    a3   = random_coord();
    if (pick < 15) begin
      cmd = CMD_COLOR;
      a0  = random_color();
      a1  = random_color();
      a2  = random_color();
    end else if (pick < 30) begin
      cmd = CMD_MOVE;
    end else if (pick < 58) begin
      cmd = CMD_LINE;
    end else if (pick < 78) begin
      cmd = CMD_TRI;
    end else if (pick < 89) begin
      cmd = CMD_DOT;
    end else begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_SPARE_A;
        1:       cmd = CMD_SPARE_B;
        default: cmd = CMD_SPARE_C;
      endcase
    end
    send_cmd(cmd, first, a0, a1, a2, a3);
  endtask

  // lists usually open with the first flag; a stray flag mid-list is rare
  task automatic run_lists(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 12);
      for (int j = 0; j < len && sent < items; j++) begin
        send_random((j == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 40) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed list under the reset limit
    send_cmd(CMD_COLOR, 1'b1, 16'd256, 16'd0, 16'd128, 16'h1234);
    send_cmd(CMD_LINE,  1'b0, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA);
    send_cmd(CMD_TRI,   1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    // color arguments beyond 0..256 clamp
    send_cmd(CMD_COLOR, 1'b0, 16'h8000, 16'h7FFF, 16'd257, 16'h0000);
    send_cmd(CMD_LINE,  1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    // ring around a pen near the corner saturates
    send_cmd(CMD_MOVE,  1'b0, 16'h7FF0, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_DOT,   1'b0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    // negative radius mirrors the ring
    send_cmd(CMD_DOT,   1'b0, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_MOVE,  1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_cmd(CMD_DOT,   1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_cmd(CMD_DOT,   1'b0, 16'd1, 16'd0, 16'd0, 16'd0);
    send_cmd(CMD_DOT,   1'b0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    // unused opcodes: counted, nothing drawn
    send_cmd(CMD_SPARE_A, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cmd(CMD_SPARE_B, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_cmd(CMD_SPARE_C, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    // new list resets pen and color before drawing
    send_cmd(CMD_LINE,  1'b1, 16'd100, 16'd200, 16'd0, 16'd0);
    send_cmd(CMD_TRI,   1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_cmd(CMD_COLOR, 1'b0, 16'd255, 16'd1, 16'd0, 16'd0);
    send_cmd(CMD_MOVE,  1'b0, 16'd16, 16'hFFF0, 16'd0, 16'd0);
    send_cmd(CMD_DOT,   1'b0, 16'd160, 16'd0, 16'd0, 16'd0);
    send_cmd(CMD_DOT,   1'b1, 16'd64, 16'd0, 16'd0, 16'd0);

    // random lists under several limits; the block is drained before each write
    run_lists(80);
    wait_drained();
    write_limit(16'd4);
    run_lists(50);
    wait_drained();
    write_limit(16'd0);
    run_lists(15);
    wait_drained();
    write_limit(16'd1);
    run_lists(25);
    wait_drained();
    write_limit(LIMIT_W'($urandom_range(2, 30)));
    run_lists(80);
    wait_drained();
    write_limit(LIMIT_RESET);
    run_lists(100);

    // every segment out, then a quiet spell to catch stray beats
    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
